FILE: design/i2c_rw_pkg.sv
`timescale 1ns / 1ps

package i2c_rw_pkg;

    // Largest accepted byte count for one transfer
    localparam logic [8:0] MAX_BYTES = 9'd256;

    // Request operations
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_EVENT = 2'd1;
    localparam logic [1:0] OP_ERROR = 2'd2;

    // Transfer modes (restart-read is internal only)
    localparam logic [1:0] MODE_WRITE   = 2'd0;
    localparam logic [1:0] MODE_READ    = 2'd1;
    localparam logic [1:0] MODE_RESTART = 2'd2;

    // Transfer status and completion codes
    localparam logic [1:0] ST_ACTIVE = 2'd0;
    localparam logic [1:0] ST_PASSED = 2'd1;
    localparam logic [1:0] ST_FAILED = 2'd2;
    localparam logic [1:0] DONE_NONE = 2'd0;

    // Start replies
    localparam logic [1:0] REPLY_OK   = 2'd0;
    localparam logic [1:0] REPLY_BUSY = 2'd1;
    localparam logic [1:0] REPLY_BAD  = 2'd2;

    // Status register bits
    localparam logic [15:0] BIT_SB     = 16'h0001;
    localparam logic [15:0] BIT_ADDR   = 16'h0002;
    localparam logic [15:0] BIT_RXNE   = 16'h0040;
    localparam logic [15:0] BIT_TXE    = 16'h0080;
    localparam logic [15:0] MASK_TXBTF = 16'h0084;
    localparam logic [15:0] BIT_BERR   = 16'h0100;
    localparam logic [15:0] BIT_ARLO   = 16'h0200;
    localparam logic [15:0] BIT_AF     = 16'h0400;
    localparam logic [15:0] BIT_OVR    = 16'h0800;

    // Control actions
    localparam logic [6:0] ACT_START  = 7'h01;
    localparam logic [6:0] ACT_STOP   = 7'h02;
    localparam logic [6:0] ACT_ACKON  = 7'h04;
    localparam logic [6:0] ACT_ACKOFF = 7'h08;
    localparam logic [6:0] ACT_BUFOFF = 7'h10;
    localparam logic [6:0] ACT_EVTOFF = 7'h20;
    localparam logic [6:0] ACT_IRQEN  = 7'h40;

    // Cleared error flag codes
    localparam logic [2:0] ERR_NONE = 3'd0;
    localparam logic [2:0] ERR_AF   = 3'd1;
    localparam logic [2:0] ERR_ARLO = 3'd2;
    localparam logic [2:0] ERR_BERR = 3'd3;
    localparam logic [2:0] ERR_OVR  = 3'd4;

    typedef struct packed {
        logic [1:0]  operation;
        logic [6:0]  slave_addr;
        logic [7:0]  reg_addr;
        logic [8:0]  byte_count;
        logic [1:0]  xfer_mode;
        logic [15:0] status_bits;
        logic [7:0]  rx_byte;
        logic [7:0]  tx_byte;
    } req_t;

    typedef struct packed {
        logic [1:0] reply;
        logic       dr_write;
        logic [7:0] dr_value;
        logic       rx_write;
        logic [7:0] rx_index;
        logic [7:0] rx_data;
        logic [6:0] ctrl_actions;
        logic [2:0] err_cleared;
        logic [1:0] xfer_status;
        logic [1:0] done_event;
        logic [8:0] tx_index;
    } rsp_t;

endpackage

FILE: design/i2c_master_register_read_write_sequencer.sv
`timescale 1ns / 1ps

// Sequencer for an I2C master register access. Each request (start, peripheral
// event or error event) yields exactly one response: data-register write,
// received byte with its buffer index, control actions, cleared error flag,
// transfer status and completion. A request is decoded against the held
// transfer state combinationally and the response lands in one output
// register, so one request is taken every cycle while the response side keeps
// up; s_ready drops only while a response is held back by m_ready.
module i2c_master_register_read_write_sequencer (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  i2c_rw_pkg::req_t  s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output i2c_rw_pkg::rsp_t  m_payload
);

    logic [1:0] mode_reg,      mode_next;
    logic [7:0] target_reg,    target_next;
    logic [7:0] register_reg,  register_next;
    logic [8:0] remaining_reg, remaining_next;
    logic [8:0] position_reg,  position_next;
    logic [1:0] status_reg,    status_next;
    logic       m_valid_reg;
    i2c_rw_pkg::rsp_t rsp_reg, rsp_next;

    logic        accept;
    logic [15:0] sr;
    logic [8:0]  rem_dec;
    logic [8:0]  pos_inc;

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = rsp_reg;

    assign sr      = s_payload.status_bits;
    assign rem_dec = remaining_reg - 9'd1;
    assign pos_inc = position_reg + 9'd1;

    always_comb begin
        mode_next      = mode_reg;
        target_next    = target_reg;
        register_next  = register_reg;
        remaining_next = remaining_reg;
        position_next  = position_reg;
        status_next    = status_reg;
        rsp_next       = '0;

        case (s_payload.operation)
            i2c_rw_pkg::OP_START: begin
                if (status_reg == i2c_rw_pkg::ST_ACTIVE) begin
                    rsp_next.reply = i2c_rw_pkg::REPLY_BUSY;
                end else if ((s_payload.xfer_mode != i2c_rw_pkg::MODE_WRITE &&
                              s_payload.xfer_mode != i2c_rw_pkg::MODE_READ) ||
                             s_payload.byte_count > i2c_rw_pkg::MAX_BYTES) begin
                    rsp_next.reply = i2c_rw_pkg::REPLY_BAD;
                end else begin
                    target_next    = {s_payload.slave_addr, 1'b0};
                    register_next  = s_payload.reg_addr;
                    status_next    = i2c_rw_pkg::ST_ACTIVE;
                    remaining_next = s_payload.byte_count;
                    position_next  = '0;
                    mode_next      = s_payload.xfer_mode;
                    rsp_next.reply = i2c_rw_pkg::REPLY_OK;
                    rsp_next.ctrl_actions = i2c_rw_pkg::ACT_IRQEN |
                                            i2c_rw_pkg::ACT_ACKON |
                                            i2c_rw_pkg::ACT_START;
                end
            end
            i2c_rw_pkg::OP_EVENT: begin
                if ((sr & i2c_rw_pkg::BIT_SB) != '0) begin
                    rsp_next.dr_write = 1'b1;
                    // Read bit goes out only after the repeated start
                    rsp_next.dr_value = target_reg |
                        {7'd0, mode_reg == i2c_rw_pkg::MODE_RESTART};
                end else if ((sr & i2c_rw_pkg::BIT_ADDR) != '0) begin
                    if (mode_reg != i2c_rw_pkg::MODE_RESTART) begin
                        rsp_next.dr_write = 1'b1;
                        rsp_next.dr_value = register_reg;
                        if (mode_reg == i2c_rw_pkg::MODE_READ) begin
                            mode_next = i2c_rw_pkg::MODE_RESTART;
                            rsp_next.ctrl_actions = rsp_next.ctrl_actions |
                                                    i2c_rw_pkg::ACT_START;
                        end
                        if (remaining_reg == '0) begin
                            rsp_next.ctrl_actions = rsp_next.ctrl_actions |
                                                    i2c_rw_pkg::ACT_BUFOFF;
                        end
                    end else if (remaining_reg == 9'd1) begin
                        rsp_next.ctrl_actions = i2c_rw_pkg::ACT_ACKOFF |
                                                i2c_rw_pkg::ACT_STOP;
                    end
                end else if ((sr & i2c_rw_pkg::MASK_TXBTF) == i2c_rw_pkg::BIT_TXE) begin
                    if (mode_reg == i2c_rw_pkg::MODE_WRITE && remaining_reg != '0) begin
                        rsp_next.dr_write = 1'b1;
                        rsp_next.dr_value = s_payload.tx_byte;
                        position_next     = pos_inc;
                        remaining_next    = rem_dec;
                        if (rem_dec == '0) begin
                            rsp_next.ctrl_actions = i2c_rw_pkg::ACT_BUFOFF;
                        end
                    end
                end else if ((sr & i2c_rw_pkg::MASK_TXBTF) == i2c_rw_pkg::MASK_TXBTF) begin
                    if (mode_reg == i2c_rw_pkg::MODE_WRITE) begin
                        rsp_next.ctrl_actions = i2c_rw_pkg::ACT_STOP |
                                                i2c_rw_pkg::ACT_EVTOFF;
                        status_next           = i2c_rw_pkg::ST_PASSED;
                        rsp_next.done_event   = i2c_rw_pkg::ST_PASSED;
                    end
                end else if ((sr & i2c_rw_pkg::BIT_RXNE) != '0) begin
                    if (remaining_reg == '0) begin
                        rsp_next.ctrl_actions = i2c_rw_pkg::ACT_BUFOFF;
                        status_next           = i2c_rw_pkg::ST_PASSED;
                        rsp_next.done_event   = i2c_rw_pkg::ST_PASSED;
                    end else begin
                        rsp_next.rx_write = 1'b1;
                        rsp_next.rx_index = position_reg[7:0];
                        rsp_next.rx_data  = s_payload.rx_byte;
                        position_next     = pos_inc;
                        remaining_next    = rem_dec;
                        // Drop ACK and set STOP ahead of the last byte
                        if (rem_dec == 9'd1) begin
                            rsp_next.ctrl_actions = i2c_rw_pkg::ACT_ACKOFF |
                                                    i2c_rw_pkg::ACT_STOP;
                        end
                        if (rem_dec == '0) begin
                            rsp_next.ctrl_actions = i2c_rw_pkg::ACT_BUFOFF;
                            status_next           = i2c_rw_pkg::ST_PASSED;
                            rsp_next.done_event   = i2c_rw_pkg::ST_PASSED;
                        end
                    end
                end
            end
            i2c_rw_pkg::OP_ERROR: begin
                // Clear only the first flag present
                if ((sr & i2c_rw_pkg::BIT_AF) != '0) begin
                    rsp_next.err_cleared = i2c_rw_pkg::ERR_AF;
                end else if ((sr & i2c_rw_pkg::BIT_ARLO) != '0) begin
                    rsp_next.err_cleared = i2c_rw_pkg::ERR_ARLO;
                end else if ((sr & i2c_rw_pkg::BIT_BERR) != '0) begin
                    rsp_next.err_cleared = i2c_rw_pkg::ERR_BERR;
                end else if ((sr & i2c_rw_pkg::BIT_OVR) != '0) begin
                    rsp_next.err_cleared = i2c_rw_pkg::ERR_OVR;
                end else begin
                    rsp_next.err_cleared = i2c_rw_pkg::ERR_NONE;
                end
                status_next         = i2c_rw_pkg::ST_FAILED;
                rsp_next.done_event = i2c_rw_pkg::ST_FAILED;
            end
            default: begin
            end
        endcase

        rsp_next.xfer_status = status_next;
        rsp_next.tx_index    = position_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= i2c_rw_pkg::MODE_WRITE;
            target_reg    <= '0;
            register_reg  <= '0;
            remaining_reg <= '0;
            position_reg  <= '0;
            status_reg    <= i2c_rw_pkg::ST_PASSED;
            m_valid_reg   <= 1'b0;
        end else begin
            if (accept) begin
                mode_reg      <= mode_next;
                target_reg    <= target_next;
                register_reg  <= register_next;
                remaining_reg <= remaining_next;
                position_reg  <= position_next;
                status_reg    <= status_next;
                m_valid_reg   <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rsp_reg <= rsp_next;
        end
    end

    a_accept_gives_response: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid_reg)
        else $error("accepted request produced no response");

    a_status_tracks_response: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> rsp_reg.xfer_status == status_reg)
        else $error("response status differs from held status");

    a_done_matches_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && rsp_reg.done_event != i2c_rw_pkg::DONE_NONE) |->
            rsp_reg.xfer_status == rsp_reg.done_event)
        else $error("completion disagrees with status");

    a_error_fails: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && rsp_reg.err_cleared != i2c_rw_pkg::ERR_NONE) |->
            rsp_reg.done_event == i2c_rw_pkg::ST_FAILED)
        else $error("error cleared without failing the transfer");

    a_position_tracks_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> rsp_reg.tx_index == position_reg)
        else $error("response index differs from held position");

endmodule

FILE: dv/tb_i2c_master_register_read_write_sequencer.sv
`timescale 1ns / 1ps

module tb_i2c_master_register_read_write_sequencer;
    import i2c_rw_pkg::*;

    localparam logic [1:0]  OP_UNUSED      = 2'd3;
    localparam logic [1:0]  MODE_UNDEFINED = 2'd3;
    localparam logic [15:0] BIT_BTF        = MASK_TXBTF & ~BIT_TXE;
    localparam logic [15:0] ERR_BITS       = BIT_BERR | BIT_ARLO | BIT_AF | BIT_OVR;
    // bits cleared so that the wanted handler wins the priority decode
    localparam logic [15:0] CLR_ADDR = BIT_SB;
    localparam logic [15:0] CLR_TXE  = BIT_SB | BIT_ADDR | BIT_BTF;
    localparam logic [15:0] CLR_BTF  = BIT_SB | BIT_ADDR;
    localparam logic [15:0] CLR_RXNE = BIT_SB | BIT_ADDR | BIT_TXE;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_ITEMS = 475;
    localparam int PRINT_LIMIT  = 200;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_payload = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rsp_t m_payload;

    // transfer state as the sequencer should hold it
    logic [1:0] cur_mode      = MODE_WRITE;
    logic [7:0] cur_addr_byte = '0;
    logic [7:0] cur_reg_byte  = '0;
    logic [8:0] bytes_left    = '0;
    logic [8:0] buf_pos       = '0;
    logic [1:0] xfer_state    = ST_PASSED;

    rsp_t expected_rsp[$];

    int unsigned src_idle_pct  = 18;
    int unsigned sink_idle_pct = 78;
    int unsigned items_sent    = 0;
    int unsigned rsp_checked   = 0;
    int unsigned n_errors      = 0;
    int unsigned n_writes      = 0;
    int unsigned n_reads       = 0;
    int unsigned n_broken      = 0;
    int          stall_cycles  = 0;
    bit          may_be_active = 1'b0;
    bit          seq_broken    = 1'b0;

    i2c_master_register_read_write_sequencer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic rsp_t predict_access(req_t r);
        rsp_t        o;
        logic [15:0] sr;
        o  = '0;
        sr = r.status_bits;
        case (r.operation)
            OP_START: begin
                if (xfer_state == ST_ACTIVE) begin
                    o.reply = REPLY_BUSY;
                end else if ((r.xfer_mode != MODE_WRITE && r.xfer_mode != MODE_READ)
                             || r.byte_count > MAX_BYTES) begin
                    o.reply = REPLY_BAD;
                end else begin
                    cur_addr_byte  = {r.slave_addr, 1'b0};
                    cur_reg_byte   = r.reg_addr;
                    xfer_state     = ST_ACTIVE;
                    bytes_left     = r.byte_count;
                    buf_pos        = '0;
                    cur_mode       = r.xfer_mode;
                    o.ctrl_actions = ACT_IRQEN | ACT_ACKON | ACT_START;
                end
            end
            OP_EVENT: begin
                if (|(sr & BIT_SB)) begin
                    o.dr_write = 1'b1;
                    // set the read bit only after the repeated start
                    o.dr_value = (cur_mode == MODE_RESTART) ? (cur_addr_byte | 8'h01)
                                                            : cur_addr_byte;
                end else if (|(sr & BIT_ADDR)) begin
                    if (cur_mode != MODE_RESTART) begin
                        o.dr_write = 1'b1;
                        o.dr_value = cur_reg_byte;
                        if (cur_mode == MODE_READ) begin
                            cur_mode = MODE_RESTART;
                            o.ctrl_actions |= ACT_START;
                        end
                        if (bytes_left == 0) o.ctrl_actions |= ACT_BUFOFF;
                    end else if (bytes_left == 1) begin
                        o.ctrl_actions |= ACT_ACKOFF | ACT_STOP;
                    end
                end else if ((sr & MASK_TXBTF) == BIT_TXE) begin
                    if (cur_mode == MODE_WRITE && bytes_left != 0) begin
                        o.dr_write = 1'b1;
                        o.dr_value = r.tx_byte;
                        buf_pos    = buf_pos + 9'd1;
                        bytes_left = bytes_left - 9'd1;
                        if (bytes_left == 0) o.ctrl_actions |= ACT_BUFOFF;
                    end
                end else if ((sr & MASK_TXBTF) == MASK_TXBTF) begin
                    if (cur_mode == MODE_WRITE) begin
                        o.ctrl_actions |= ACT_STOP | ACT_EVTOFF;
                        xfer_state      = ST_PASSED;
                        o.done_event    = ST_PASSED;
                    end
                end else if (|(sr & BIT_RXNE)) begin
                    if (bytes_left == 0) begin
                        o.ctrl_actions |= ACT_BUFOFF;
                        xfer_state      = ST_PASSED;
                        o.done_event    = ST_PASSED;
                    end else begin
                        o.rx_write = 1'b1;
                        o.rx_index = buf_pos[7:0];
                        o.rx_data  = r.rx_byte;
                        buf_pos    = buf_pos + 9'd1;
                        bytes_left = bytes_left - 9'd1;
                        // drop ACK and queue STOP ahead of the last byte
                        if (bytes_left == 1) o.ctrl_actions |= ACT_ACKOFF | ACT_STOP;
                        if (bytes_left == 0) begin
                            o.ctrl_actions |= ACT_BUFOFF;
                            xfer_state      = ST_PASSED;
                            o.done_event    = ST_PASSED;
                        end
                    end
                end
            end
            OP_ERROR: begin
                if (|(sr & BIT_AF))        o.err_cleared = ERR_AF;
                else if (|(sr & BIT_ARLO)) o.err_cleared = ERR_ARLO;
                else if (|(sr & BIT_BERR)) o.err_cleared = ERR_BERR;
                else if (|(sr & BIT_OVR))  o.err_cleared = ERR_OVR;
                xfer_state   = ST_FAILED;
                o.done_event = ST_FAILED;
            end
            default: ;
        endcase
        o.xfer_status = xfer_state;
        o.tx_index    = buf_pos;
        return o;
    endfunction

    task automatic report_mismatch(string msg);
        if (n_errors < PRINT_LIMIT) $display("ERROR @%0t: %s", $time, msg);
        n_errors++;
    endtask

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
            report_mismatch($sformatf("%s: expected 0x%0h, got 0x%0h", name, want, got));
    endtask

    function automatic req_t random_req();
        req_t        r;
        logic [63:0] rnd_bits;
        rnd_bits = {$urandom, $urandom};
        r        = rnd_bits[$bits(req_t)-1:0];
        return r;
    endfunction

    task automatic push_request(req_t r);
        if ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_valid   <= 1'b1;
        s_payload <= r;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_rsp.size() != 0) @(posedge aclk);
    endtask

    task automatic send_start(logic [1:0] mode, logic [8:0] count, logic [6:0] sa,
                              logic [7:0] ra);
        req_t r;
        r            = random_req();
        r.operation  = OP_START;
        r.xfer_mode  = mode;
        r.byte_count = count;
        r.slave_addr = sa;
        r.reg_addr   = ra;
        push_request(r);
    endtask

    task automatic send_event(logic [15:0] set_bits, logic [15:0] clear_bits,
                              logic [7:0] rxb, logic [7:0] txb);
        req_t r;
        r             = random_req();
        r.operation   = OP_EVENT;
        r.status_bits = (r.status_bits & ~clear_bits) | set_bits;
        r.rx_byte     = rxb;
        r.tx_byte     = txb;
        push_request(r);
    endtask

    task automatic send_error(logic [15:0] flags);
        req_t r;
        r             = random_req();
        r.operation   = OP_ERROR;
        r.status_bits = (r.status_bits & ~ERR_BITS) | flags;
        push_request(r);
    endtask

    // one event of a well-formed sequence, now and then broken or interleaved with noise
    task automatic seq_step(logic [15:0] set_bits, logic [15:0] clear_bits);
        if (seq_broken) return;
        if ($urandom_range(99) < 2) begin
            send_error(16'($urandom) & ERR_BITS);
            seq_broken = 1'b1;
            n_broken++;
            return;
        end
        if ($urandom_range(99) < 3) begin
            push_request(random_req());
            may_be_active = 1'b1;
        end
        send_event(set_bits, clear_bits, 8'($urandom), 8'($urandom));
    endtask

    task automatic run_transfer();
        logic        is_read;
        int unsigned pick;
        logic [8:0]  count;
        is_read = 1'($urandom_range(1));
        pick    = $urandom_range(99);
        if (pick < 80)      count = 9'($urandom_range(6));
        else if (pick < 99) count = 9'($urandom_range(40, 7));
        else                count = 9'($urandom_range(MAX_BYTES, 240));
        // abort anything noise may have left running, so the start is taken
        if (may_be_active) begin
            send_error(16'($urandom) & ERR_BITS);
            may_be_active = 1'b0;
        end
        seq_broken = 1'b0;
        send_start(is_read ? MODE_READ : MODE_WRITE, count, 7'($urandom), 8'($urandom));
        if ($urandom_range(99) < 5)
            send_start(2'($urandom_range(3)), 9'($urandom), 7'($urandom), 8'($urandom));
        seq_step(BIT_SB, '0);
        seq_step(BIT_ADDR, CLR_ADDR);
        if (is_read) begin
            seq_step(BIT_SB, '0);
            seq_step(BIT_ADDR, CLR_ADDR);
            repeat (count) seq_step(BIT_RXNE, CLR_RXNE);
            if (count == 0) seq_step(BIT_RXNE, CLR_RXNE);
        end else begin
            repeat (count) seq_step(BIT_TXE, CLR_TXE);
            seq_step(MASK_TXBTF, CLR_BTF);
        end
        if (!seq_broken) begin
            if (is_read) n_reads++;
            else n_writes++;
        end
    endtask

    task automatic test_idle_events();
        req_t r;
        send_event(BIT_RXNE, CLR_RXNE, 8'hFF, 8'h00);
        send_event(MASK_TXBTF, CLR_BTF, 8'h00, 8'hFF);
        send_event(BIT_SB, '0, 8'h00, 8'h00);
        r             = random_req();
        r.operation   = OP_UNUSED;
        r.status_bits = 16'hFFFF;
        push_request(r);
    endtask

    task automatic test_start_rejects();
        send_start(MODE_RESTART, 9'd1, 7'h12, 8'h34);
        send_start(MODE_UNDEFINED, 9'd1, 7'h12, 8'h34);
        send_start(MODE_WRITE, MAX_BYTES + 9'd1, 7'h12, 8'h34);
        send_start(MODE_WRITE, MAX_BYTES, 7'h7F, 8'hFF);
        send_start(MODE_READ, 9'd0, 7'h00, 8'h00);
        send_error('0);
    endtask

    task automatic test_error_flags();
        send_error(ERR_BITS);
        send_error(BIT_ARLO | BIT_BERR | BIT_OVR);
        send_error(BIT_BERR | BIT_OVR);
        send_error(BIT_OVR);
    endtask

    task automatic test_write_transfer();
        send_start(MODE_WRITE, 9'd2, 7'h55, 8'hA5);
        send_event(BIT_SB, '0, 8'h00, 8'h00);
        send_event(BIT_ADDR, CLR_ADDR, 8'h00, 8'h00);
        send_event(BIT_TXE, CLR_TXE, 8'h00, 8'hFF);
        send_event(BIT_TXE, CLR_TXE, 8'hFF, 8'h00);
        send_event(BIT_TXE, CLR_TXE, 8'h5A, 8'h5A);
        send_event(MASK_TXBTF, CLR_BTF, 8'h00, 8'h00);
    endtask

    task automatic test_read_transfer();
        send_start(MODE_READ, 9'd1, 7'h00, 8'h00);
        send_event(BIT_SB, '0, 8'h00, 8'h00);
        send_event(BIT_ADDR, CLR_ADDR, 8'h00, 8'h00);
        send_event(BIT_SB, '0, 8'h00, 8'h00);
        send_event(BIT_ADDR, CLR_ADDR, 8'h00, 8'h00);
        send_event(BIT_RXNE, CLR_RXNE, 8'hFF, 8'h00);
    endtask

    task automatic test_random_traffic(int unsigned src_pct, int unsigned sink_pct,
                                       int unsigned n_items);
        int unsigned stop_at;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        stop_at       = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 12) begin
                push_request(random_req());
                may_be_active = 1'b1;
            end else begin
                run_transfer();
            end
            if ($urandom_range(99) < 3) wait_for_results();
        end
        wait_for_results();
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge aclk) begin : rsp_check
        rsp_t want;
        if (aresetn) begin
            if (s_valid && s_ready) expected_rsp.push_back(predict_access(s_payload));
            if (m_valid && m_ready) begin
                if (expected_rsp.size() == 0) begin
                    report_mismatch("response with no request outstanding");
                end else begin
                    want = expected_rsp.pop_front();
                    rsp_checked++;
                    check_field("reply", 16'(want.reply), 16'(m_payload.reply));
                    check_field("dr_write", 16'(want.dr_write), 16'(m_payload.dr_write));
                    check_field("dr_value", 16'(want.dr_value), 16'(m_payload.dr_value));
                    check_field("rx_write", 16'(want.rx_write), 16'(m_payload.rx_write));
                    check_field("rx_index", 16'(want.rx_index), 16'(m_payload.rx_index));
                    check_field("rx_data", 16'(want.rx_data), 16'(m_payload.rx_data));
                    check_field("ctrl_actions", 16'(want.ctrl_actions),
                                16'(m_payload.ctrl_actions));
                    check_field("err_cleared", 16'(want.err_cleared),
                                16'(m_payload.err_cleared));
                    check_field("xfer_status", 16'(want.xfer_status),
                                16'(m_payload.xfer_status));
                    check_field("done_event", 16'(want.done_event),
                                16'(m_payload.done_event));
                    check_field("tx_index", 16'(want.tx_index), 16'(m_payload.tx_index));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no request or response moved for %0d cycles", STALL_LIMIT);
            $display("tb_i2c_master_register_read_write_sequencer: FAIL");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        test_idle_events();
        test_start_rejects();
        test_error_flags();
        test_write_transfer();
        test_read_transfer();
        wait_for_results();
        test_random_traffic(18, 78, RANDOM_ITEMS);
        test_random_traffic(78, 18, RANDOM_ITEMS);
        test_random_traffic(0, 0, RANDOM_ITEMS);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_rsp.size() != 0)
            report_mismatch($sformatf("%0d responses never arrived", expected_rsp.size()));
        $display("Covered %0d requests: %0d write and %0d read sequences completed,",
                 items_sent, n_writes, n_reads);
        $display("%0d cut short; checked %0d responses, %0d mismatches",
                 n_broken, rsp_checked, n_errors);
        if (n_errors == 0) begin
            $display("tb_i2c_master_register_read_write_sequencer: PASS");
        end else begin
            $display("tb_i2c_master_register_read_write_sequencer: FAIL");
        end
        $finish;
    end

endmodule
